FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CTI_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cti_pkg.sv
// ----------------------------------------------------------------------------
// cti_pkg
// Shared constants, types and the restoring divide step of the cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cti_pkg;

  localparam int TEXT_MAX_DEF = 64;
  localparam int KEY_MAX_DEF  = 24;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h78;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HI  = 3'd4;

  typedef struct packed {
    logic             busy;
    logic             mode;
    logic [LEN_W-1:0] len;
  } key_stat_t;

  typedef struct packed {
    logic [LEN_W-1:0] rem;
    logic             q;
  } div_step_t;

  // one bit of a restoring division by a key length
  function automatic div_step_t div_step(input logic [LEN_W-1:0] rem,
                                         input logic             din,
                                         input logic [LEN_W-1:0] dvs);
    logic [LEN_W:0] t;
    div_step_t      r;
    t = {rem, din};
    if (t >= {1'b0, dvs}) begin
      r.rem = LEN_W'(t - {1'b0, dvs});
      r.q   = 1'b1;
    end else begin
      r.rem = t[LEN_W-1:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cti_ram.sv
// ----------------------------------------------------------------------------
// cti_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/cti_rank.sv
// ----------------------------------------------------------------------------
// cti_rank
// Key registers, column ranking one key position per cycle, capacity divide.
// ----------------------------------------------------------------------------
`default_nettype none

module cti_rank #(
  parameter int TEXT_MAX = cti_pkg::TEXT_MAX_DEF,
  parameter int KEY_MAX  = cti_pkg::KEY_MAX_DEF,
  localparam int KA_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1,
  localparam int CW   = $clog2(TEXT_MAX + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cti_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cti_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cti_pkg::key_stat_t               kstat,
  output logic [CW-1:0]                    cap,
  output logic                             map_we,
  output logic [KA_W-1:0]                  map_waddr,
  output logic [cti_pkg::LEN_W-1:0]        map_wdata
);

  import cti_pkg::*;

  localparam int CBW = $clog2(CW);
  localparam logic [CW-1:0] TM = CW'(TEXT_MAX);

  typedef enum logic [1:0] {R_RANK, R_CAP, R_IDLE} rstate_t;

  rstate_t                 state_r;
  logic [KA_W-1:0]         i_r;
  logic [CBW-1:0]          bc_r;
  logic [LEN_W-1:0]        rem_r;
  logic [CW-1:0]           cap_r;
  logic                    mode_r;
  logic [LEN_W-1:0]        klen_r;
  logic [CFG_DATA_W-1:0]   key_lo_r;
  logic [CFG_DATA_W-1:0]   key_mid_r;
  logic [CFG_DATA_W-1:0]   key_hi_r;

  logic [3*CFG_DATA_W-1:0] key_flat;
  logic [BYTE_W-1:0]       key_b [KEY_MAX];
  logic [BYTE_W-1:0]       ki;
  logic [KEY_MAX-1:0]      lt;
  logic [LEN_W-1:0]        col;
  logic [LEN_W-1:0]        len;
  logic                    cfg_hit;
  div_step_t               st;

  assign key_flat = {key_hi_r, key_mid_r, key_lo_r};

  always_comb begin
    if (klen_r == '0) begin
      len = LEN_W'(1);
    end else if (klen_r > LEN_W'(KEY_MAX)) begin
      len = LEN_W'(KEY_MAX);
    end else begin
      len = klen_r;
    end
  end

  always_comb begin
    for (int j = 0; j < KEY_MAX; j++) begin
      key_b[j] = key_flat[j*BYTE_W +: BYTE_W];
    end
  end

  assign ki = key_b[i_r];

  always_comb begin
    for (int j = 0; j < KEY_MAX; j++) begin
      lt[j] = (LEN_W'(j) < len) &&
              ((key_b[j] < ki) || ((key_b[j] == ki) && (KA_W'(j) < i_r)));
    end
  end

  assign col = LEN_W'($countones(lt));
  assign st  = div_step(rem_r, TM[bc_r], len);

  assign cfg_ready = (state_r == R_IDLE);
  assign cfg_hit   = cfg_valid && cfg_ready && (cfg_index <= REG_KEY_HI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= R_RANK;
      i_r       <= '0;
      bc_r      <= '0;
      rem_r     <= '0;
      cap_r     <= '0;
      mode_r    <= 1'b0;
      klen_r    <= LEN_W'(1);
      key_lo_r  <= '0;
      key_mid_r <= '0;
      key_hi_r  <= '0;
    end else begin
      unique case (state_r)
        R_RANK: begin
          if (LEN_W'(i_r) == len - LEN_W'(1)) begin
            state_r <= R_CAP;
            i_r     <= '0;
            bc_r    <= CBW'(CW - 1);
            rem_r   <= '0;
          end else begin
            i_r <= i_r + KA_W'(1);
          end
        end
        R_CAP: begin
          rem_r <= st.rem;
          if (bc_r == '0) begin
            cap_r   <= TM - CW'(st.rem);
            state_r <= R_IDLE;
          end else begin
            bc_r <= bc_r - CBW'(1);
          end
        end
        R_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              REG_MODE:    mode_r    <= cfg_data[0];
              REG_LEN:     klen_r    <= cfg_data[LEN_W-1:0];
              REG_KEY_LO:  key_lo_r  <= cfg_data;
              REG_KEY_MID: key_mid_r <= cfg_data;
              REG_KEY_HI:  key_hi_r  <= cfg_data;
              default: ;
            endcase
          end
          if (cfg_hit) begin
            state_r <= R_RANK;
            i_r     <= '0;
          end
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  // encrypt: map[position] = column; decrypt: map[column] = position
  assign map_we    = (state_r == R_RANK);
  assign map_waddr = mode_r ? KA_W'(col) : i_r;
  assign map_wdata = mode_r ? LEN_W'(i_r) : col;

  assign kstat.busy = (state_r != R_IDLE);
  assign kstat.mode = mode_r;
  assign kstat.len  = len;
  assign cap        = cap_r;

`include "assert_macros.svh"

  `CTI_ASSERT_NEXT(a_cfg_restarts_rank, cfg_hit, kstat.busy, "config write did not restart ranking")
  `CTI_ASSERT(a_rank_index_in_key, state_r == R_RANK, LEN_W'(i_r) < len, "rank index beyond key")

endmodule

`default_nettype wire

FILE: hw/rtl/cti_ctrl.sv
// ----------------------------------------------------------------------------
// cti_ctrl
// Message buffer load, row count divide and permuted read-out pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cti_ctrl #(
  parameter int TEXT_MAX = cti_pkg::TEXT_MAX_DEF,
  parameter int KEY_MAX  = cti_pkg::KEY_MAX_DEF,
  localparam int KA_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1,
  localparam int CW   = $clog2(TEXT_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cti_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          in_last,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cti_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_last,
  output logic                          out_ovf,
  input  cti_pkg::key_stat_t            kstat,
  input  logic [CW-1:0]                 cap,
  output logic                          map_re,
  output logic [KA_W-1:0]               map_raddr,
  input  logic [cti_pkg::LEN_W-1:0]     map_rdata
);

  import cti_pkg::*;

  localparam int AW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  localparam int DW = $clog2(TEXT_MAX + KEY_MAX);
  localparam int BW = $clog2(DW);
  localparam int PW = CW + LEN_W;

  typedef enum logic [1:0] {C_LOAD, C_DIV, C_EMIT, C_DRAIN} cstate_t;

  cstate_t           state_r;
  logic [CW-1:0]     cnt_r;
  logic              drop_r;
  logic [CW-1:0]     n_r;
  logic              ovf_r;
  logic              mode_r;
  logic [LEN_W-1:0]  len_r;
  logic [DW-1:0]     d_r;
  logic [LEN_W-1:0]  rem_r;
  logic [DW-1:0]     q_r;
  logic [BW-1:0]     bc_r;
  logic [CW-1:0]     rows_r;
  logic [CW-1:0]     klim_r;
  logic [CW-1:0]     olim_r;
  logic [CW-1:0]     k_r;
  logic [CW-1:0]     o_r;
  logic              v1_r;
  logic [CW-1:0]     k1_r;
  logic [CW-1:0]     o1_r;
  logic              last1_r;
  logic              v2_r;
  logic [AW-1:0]     src2_r;
  logic              pad2_r;
  logic              last2_r;
  logic              v3_r;
  logic              pad3_r;
  logic              last3_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_ovf_r;

  logic              in_acc;
  logic              store;
  logic [CW-1:0]     cnt_inc;
  logic [CW-1:0]     n_last;
  logic              drop_last;
  logic              adv;
  div_step_t         st;
  logic [DW-1:0]     q_nxt;
  logic [CW-1:0]     rows_nxt;
  logic              emit_last;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     sum;
  logic              pad1;
  logic [BYTE_W-1:0] text_rdata;

  assign in_tready = (state_r == C_LOAD) && !kstat.busy;
  assign in_acc    = in_tvalid && in_tready;
  assign store     = (cnt_r < cap);
  assign cnt_inc   = cnt_r + CW'(store);
  assign n_last    = (cnt_inc > cap) ? cap : cnt_inc;
  assign drop_last = drop_r || !store || (cnt_inc > cap);

  assign adv = !out_valid_r || out_tready;

  assign st       = div_step(rem_r, d_r[bc_r], len_r);
  assign q_nxt    = {q_r[DW-2:0], st.q};
  assign rows_nxt = CW'(q_nxt);

  assign emit_last = (k_r == klim_r - CW'(1)) && (o_r == olim_r - CW'(1));

  assign map_re    = adv;
  assign map_raddr = mode_r ? KA_W'(k_r) : KA_W'(o_r);

  // encrypt: row * len + column; decrypt: position * rows + row
  assign prod = mode_r ? PW'(rows_r) * PW'(map_rdata) : PW'(k1_r) * PW'(len_r);
  assign sum  = prod + (mode_r ? PW'(o1_r) : PW'(map_rdata));
  assign pad1 = (sum >= PW'(n_r));

  cti_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TEXT_MAX)
  ) u_text_ram (
    .clk   (clk),
    .we    (in_acc && store),
    .waddr (AW'(cnt_r)),
    .wdata (in_byte),
    .re    (adv),
    .raddr (src2_r),
    .rdata (text_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        C_LOAD: begin
          if (in_acc) begin
            if (in_last) begin
              cnt_r  <= '0;
              drop_r <= 1'b0;
              if (n_last != '0) begin
                state_r <= C_DIV;
                n_r     <= n_last;
                ovf_r   <= drop_last;
                mode_r  <= kstat.mode;
                len_r   <= kstat.len;
                d_r     <= DW'(n_last) + DW'(kstat.len) - DW'(1);
                rem_r   <= '0;
                q_r     <= '0;
                bc_r    <= BW'(DW - 1);
              end
            end else begin
              cnt_r  <= cnt_inc;
              drop_r <= drop_r || !store;
            end
          end
        end
        C_DIV: begin
          rem_r <= st.rem;
          q_r   <= q_nxt;
          if (bc_r == '0) begin
            rows_r  <= rows_nxt;
            klim_r  <= mode_r ? CW'(len_r) : rows_nxt;
            olim_r  <= mode_r ? rows_nxt : CW'(len_r);
            k_r     <= '0;
            o_r     <= '0;
            state_r <= C_EMIT;
          end else begin
            bc_r <= bc_r - BW'(1);
          end
        end
        C_EMIT: begin
          if (adv) begin
            if (k_r == klim_r - CW'(1)) begin
              k_r <= '0;
              o_r <= o_r + CW'(1);
            end else begin
              k_r <= k_r + CW'(1);
            end
            if (emit_last) begin
              state_r <= C_DRAIN;
            end
          end
        end
        C_DRAIN: begin
          if (!v1_r && !v2_r && !v3_r) begin
            state_r <= C_LOAD;
          end
        end
        default: state_r <= C_LOAD;
      endcase

      if (adv) begin
        v1_r        <= (state_r == C_EMIT);
        k1_r        <= k_r;
        o1_r        <= o_r;
        last1_r     <= emit_last;
        v2_r        <= v1_r;
        src2_r      <= AW'(sum);
        pad2_r      <= pad1;
        last2_r     <= last1_r;
        v3_r        <= v2_r;
        pad3_r      <= pad2_r;
        last3_r     <= last2_r;
        out_valid_r <= v3_r;
        out_byte_r  <= pad3_r ? PAD_BYTE : text_rdata;
        out_last_r  <= last3_r;
        out_ovf_r   <= ovf_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_ovf    = out_ovf_r;

`include "assert_macros.svh"

  `CTI_ASSERT(a_load_pipe_empty, state_r == C_LOAD, !v1_r && !v2_r && !v3_r, "buffer reload with reads in flight")
  `CTI_ASSERT(a_emit_counters_bound, state_r == C_EMIT, (k_r < klim_r) && (o_r < olim_r), "read-out counters out of range")

endmodule

`default_nettype wire

FILE: hw/rtl/columnar_transposition_cipher_unit.sv
// Input bytes are taken one per cycle while the unit is loading and no key
// ranking is busy. After the last byte a row divide runs, then results pass
// through the map RAM, address multiply, text RAM and output register; one byte per cycle while the receiver is ready.
// A config write starts key ranking and the capacity divide.
// Reset: synchronous, active low; the reset key is ranked before
// the first transaction is taken.
// ----------------------------------------------------------------------------
// columnar_transposition_cipher_unit
// Keyword columnar transposition, encrypt or decrypt, one message at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module columnar_transposition_cipher_unit #(
  parameter int TEXT_MAX = cti_pkg::TEXT_MAX_DEF,
  parameter int KEY_MAX  = cti_pkg::KEY_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] in_byte
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] out_byte
  output logic                           out_tlast,
  output logic                           out_tuser,  // [0] overflow
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cti_pkg::CFG_DATA_W-1:0] cfg_data
);

  import cti_pkg::*;

  localparam int KA_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int CW   = $clog2(TEXT_MAX + 1);

  key_stat_t         kstat;
  logic [CW-1:0]     cap;
  logic              map_we;
  logic [KA_W-1:0]   map_waddr;
  logic [LEN_W-1:0]  map_wdata;
  logic              map_re;
  logic [KA_W-1:0]   map_raddr;
  logic [LEN_W-1:0]  map_rdata;

  cti_rank #(
    .TEXT_MAX (TEXT_MAX),
    .KEY_MAX  (KEY_MAX)
  ) u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .kstat     (kstat),
    .cap       (cap),
    .map_we    (map_we),
    .map_waddr (map_waddr),
    .map_wdata (map_wdata)
  );

  cti_ram #(
    .WIDTH (LEN_W),
    .DEPTH (KEY_MAX)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  cti_ctrl #(
    .TEXT_MAX (TEXT_MAX),
    .KEY_MAX  (KEY_MAX)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_ovf    (out_tuser),
    .kstat      (kstat),
    .cap        (cap),
    .map_re     (map_re),
    .map_raddr  (map_raddr),
    .map_rdata  (map_rdata)
  );

endmodule

`default_nettype wire

FILE: tb/tb_columnar_transposition_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_columnar_transposition_cipher_unit
// Self-checking bench for the keyword columnar transposition unit. Messages
// are streamed in under a series of key, length and mode settings, including
// capacity overflow and a length change with a message half loaded. A scoreboard
// permutes every finished message and compares each output transaction in
// order, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_columnar_transposition_cipher_unit;
  import cti_pkg::*;

  localparam int          TEXT_CAP   = 64;
  localparam int          KEY_CAP    = 24;
  localparam int          DRAIN_GAP  = 24;
  localparam int          HOLD_SPAN  = 400;
  localparam int unsigned QUIET_MAX  = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } cipher_byte_t;

  class transposition_scoreboard;
    logic         decrypt;
    logic [4:0]   len_reg;
    logic [63:0]  key_word [3];
    logic [7:0]   held [TEXT_CAP];
    int unsigned  held_cnt;
    logic         lost;
    cipher_byte_t due_bytes [$];
    int unsigned  faults;

    function new();
      decrypt  = 1'b0;
      len_reg  = 5'd1;
      key_word = '{64'd0, 64'd0, 64'd0};
      held_cnt = 0;
      lost     = 1'b0;
      faults   = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MODE:    decrypt = val[0];
        REG_LEN:     len_reg = val[4:0];
        REG_KEY_LO:  key_word[0] = val;
        REG_KEY_MID: key_word[1] = val;
        REG_KEY_HI:  key_word[2] = val;
        default: ;
      endcase
    endfunction

    function int unsigned columns();
      if (len_reg == 5'd0) return 1;
      if (len_reg > KEY_CAP) return KEY_CAP;
      return len_reg;
    endfunction

    function logic [7:0] key_char(int unsigned i);
      return key_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function void permute_message(int unsigned cols, int unsigned n);
      int unsigned  padded, rows, col, pos, r;
      int unsigned  rank [KEY_CAP];
      logic [7:0]   src [TEXT_CAP];
      logic [7:0]   dst [TEXT_CAP];
      cipher_byte_t item;
      padded = ((n + cols - 1) / cols) * cols;
      rows   = padded / cols;
      for (int i = 0; i < cols; i++) begin
        r = 1;
        for (int j = 0; j < cols; j++) begin
          if (key_char(j) < key_char(i)) r++;
          else if (key_char(j) == key_char(i) && j < i) r++;
        end
        rank[i] = r;
      end
      for (int x = 0; x < padded; x++) src[x] = (x < n) ? held[x] : PAD_BYTE;
      for (int x = 0; x < padded; x++) begin
        col = rank[x / rows] - 1;
        pos = (x % rows) * cols + col;
        if (decrypt) dst[pos] = src[x];
        else dst[x] = src[pos];
      end
      for (int x = 0; x < padded; x++) begin
        item.data = dst[x];
        item.last = (x + 1 == padded);
        item.ovf  = lost;
        due_bytes.push_back(item);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic l);
      int unsigned cols, cap, n;
      cols = columns();
      cap  = (TEXT_CAP / cols) * cols;
      if (held_cnt < cap) begin
        held[held_cnt] = b;
        held_cnt++;
      end else begin
        lost = 1'b1;
      end
      if (!l) return;
      n = held_cnt;
      if (n > cap) begin
        n    = cap;
        lost = 1'b1;
      end
      if (n != 0) permute_message(cols, n);
      held_cnt = 0;
      lost     = 1'b0;
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic ovf);
      cipher_byte_t want;
      if (due_bytes.size() == 0) begin
        $error("out_byte: no transaction expected, got %0h", data);
        faults++;
        return;
      end
      want = due_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %0h, got %0h", want.data, data);
        faults++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, last);
        faults++;
      end
      if (ovf !== want.ovf) begin
        $error("overflow: expected %0b, got %0b", want.ovf, ovf);
        faults++;
      end
    endfunction

    function void flush_check();
      if (due_bytes.size() != 0) begin
        $error("out_byte: %0d expected transactions never arrived", due_bytes.size());
        faults++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  transposition_scoreboard sb;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_gen     = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet        = 0;

  columnar_transposition_cipher_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen  <= hold_gen;
      hold_left  <= HOLD_SPAN;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast, out_tuser);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, l);
  endtask

  task automatic send_message(input int unsigned len);
    for (int k = 0; k < len; k++) send_byte($urandom_range(255), k == len - 1);
  endtask

  task automatic send_partial(input int unsigned len);
    for (int k = 0; k < len; k++) send_byte($urandom_range(255), 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.due_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    case ($urandom_range(3))
      0: k = '0;
      1: k = '1;
      2: for (int b = 0; b < 8; b++) k[b * 8 +: 8] = 8'h61 + 8'($urandom_range(3));
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  function automatic logic [63:0] pick_len();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'd24;
      3: return 64'($urandom_range(25, 31));
      default: return 64'($urandom_range(2, 23));
    endcase
  endfunction

  initial begin
    int unsigned send_plan  [4] = '{0, 48, 0, 13};
    int unsigned stall_plan [4] = '{0, 0, 48, 13};
    int unsigned sent, budget, msg_len;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset key: one column, identity
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();

    // keyword with repeated letters, encrypt then decrypt
    write_reg(REG_KEY_LO, 64'h0000_414E_414E_4142);
    write_reg(REG_LEN, 64'd6);
    write_reg(REG_MODE, 64'd0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_message(7);
    wait_drained();
    write_reg(REG_MODE, 64'd1);
    send_message(8);

    // zero length acts as one column
    wait_drained();
    write_reg(REG_LEN, 64'd0);
    send_message(1);

    // length change with a message half loaded, oversize length clamps
    wait_drained();
    write_reg(REG_KEY_MID, '1);
    write_reg(REG_KEY_HI, 64'h0102_0304_0506_0708);
    write_reg(REG_MODE, 64'd0);
    write_reg(REG_LEN, 64'd3);
    send_partial(3);
    wait_drained();
    write_reg(REG_LEN, 64'd31);
    send_message(1);

    for (int grp = 0; grp < 8; grp++) begin
      wait_drained();
      send_gap_pct = send_plan[grp % 4];
      stall_pct    = stall_plan[grp % 4];
      write_reg(REG_MODE, 64'($urandom_range(1)));
      write_reg(REG_LEN, pick_len());
      write_reg(REG_KEY_LO, pick_key());
      write_reg(REG_KEY_MID, pick_key());
      write_reg(REG_KEY_HI, pick_key());
      budget = (grp == 0) ? 16 : 4;
      if (grp == 0) hold_gen++;
      sent = 0;
      while (sent < budget) begin
        msg_len = $urandom_range(1, 8);
        send_message(msg_len);
        sent += msg_len;
      end
    end

    // overrun capacity: bytes past 44 are dropped, last one included
    wait_drained();
    send_gap_pct = 13;
    stall_pct    = 13;
    write_reg(REG_MODE, 64'($urandom_range(1)));
    write_reg(REG_LEN, 64'd22);
    send_message(46);

    // load under a wide capacity, then shrink it before the last byte
    wait_drained();
    write_reg(REG_LEN, 64'd8);
    send_partial(46);
    wait_drained();
    write_reg(REG_LEN, 64'd22);
    write_reg(REG_MODE, 64'($urandom_range(1)));
    send_message(1);

    wait_drained();
    sb.flush_check();
    if (sb.faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
